// ----- rtl/i2cra_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// I2C register access package
// Shared widths, reset values and register indexes.
// ----------------------------------------------------------------------------
package i2cra_pkg;
  localparam int DividerWidthDefault = 8;
  localparam int CfgAddrWidth = 1;
  localparam int CfgDataWidth = 16;
  localparam logic [CfgAddrWidth-1:0] CFG_CLOCK_DIVIDER = 1'd0;
  localparam logic [CfgAddrWidth-1:0] CFG_RECEIVE_TIMEOUT = 1'd1;
  localparam logic [7:0] DIVIDER_RESET = 8'd12;
  localparam logic [15:0] TIMEOUT_RESET = 16'd10000;
endpackage
`default_nettype wire

// ----- rtl/i2c_register_access_master.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// I2C register access master
// Single-byte register write/read master, one beat per bus sampling tick.
// Each result beat is registered, or held in the skid stage while the output
// stalls. Throughput: one beat per cycle while the skid stage is empty; an
// output register with skid stage decouples the two sides. Bus timing is set
// by the quarter-bit phase counter. Reset (rst_n, synchronous) returns to idle
// with the divider at 12 and the receive timeout at 10000 ticks.
// ----------------------------------------------------------------------------
module i2c_register_access_master
  import i2cra_pkg::*;
#(
  parameter int DIVIDER_WIDTH = DividerWidthDefault
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire logic [CfgAddrWidth-1:0] cfg_addr,
  input  wire logic [CfgDataWidth-1:0] cfg_wdata,
  input  wire logic                    in_tvalid,
  output logic                         in_tready,
  // start_request, mode, slave_address, register_address, write_data,
  // sda_in, scl_in, zero pad
  input  wire logic [31:0]             in_tdata,
  output logic                         out_tvalid,
  input  wire logic                    out_tready,
  // scl_release, sda_release, busy_res, done_res, failed, read_data, zero pad
  output logic [15:0]                  out_tdata
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_START, ST_ADDR_W, ST_REG, ST_DATA,
    ST_RSTART, ST_ADDR_R, ST_RECV, ST_MNACK, ST_STOP
  } state_t;

  localparam logic [DIVIDER_WIDTH-1:0] PhaseOne = DIVIDER_WIDTH'(1);

  logic [7:0]               div_r;
  logic [15:0]              tmo_r;
  state_t                   st_r, st_nxt;
  logic [DIVIDER_WIDTH-1:0] ph_r, ph_nxt;
  logic [1:0]               q_r, q_nxt;
  logic [3:0]               bc_r, bc_nxt;
  logic [7:0]               sb_r, sb_nxt;
  logic [6:0]               hs_r, hs_nxt;
  logic [7:0]               hr_r, hr_nxt, hd_r, hd_nxt;
  logic                     hm_r, hm_nxt;
  logic [15:0]              wc_r, wc_nxt;
  logic                     err_r, err_nxt;
  logic [7:0]               lr_r, lr_nxt;
  logic                     done;
  logic [15:0]              res;
  logic [15:0]              ob_r, sk_r;
  logic                     ov_r, sv_r;
  logic                     take;

  function automatic logic is_send(state_t s);
    return s == ST_ADDR_W || s == ST_REG || s == ST_DATA || s == ST_ADDR_R;
  endfunction

  function automatic logic scl_lvl(state_t s, logic [1:0] q);
    unique case (s)
      ST_IDLE:  return 1'b1;
      ST_START: return q != 2'd3;
      ST_STOP:  return q != 2'd0;
      default:  return q == 2'd1 || q == 2'd2;
    endcase
  endfunction

  function automatic logic sda_lvl(state_t s, logic [1:0] q, logic [3:0] bc,
                                   logic [7:0] sb);
    unique case (s)
      ST_IDLE:             return 1'b1;
      ST_START, ST_RSTART: return !q[1];
      ST_STOP:             return q[1];
      ST_RECV, ST_MNACK:   return 1'b1;
      default:             return bc[3] ? 1'b1 : sb[3'd7 - bc[2:0]];
    endcase
  endfunction

  assign in_tready = !sv_r;
  assign take = in_tvalid && in_tready;

  always_comb begin
    logic   moved;
    state_t prev_st;
    logic   sda, scl;
    logic [DIVIDER_WIDTH-1:0] limit;
    moved = 1'b0;
    prev_st = st_r;
    sda = in_tdata[25];
    scl = in_tdata[26];
    limit = DIVIDER_WIDTH'(div_r);
    st_nxt = st_r; ph_nxt = ph_r; q_nxt = q_r; bc_nxt = bc_r; sb_nxt = sb_r;
    hs_nxt = hs_r; hr_nxt = hr_r; hd_nxt = hd_r; hm_nxt = hm_r; wc_nxt = wc_r;
    err_nxt = err_r; lr_nxt = lr_r; done = 1'b0;
    if (st_r == ST_IDLE) begin
      if (in_tdata[0]) begin
        hm_nxt = in_tdata[1];
        hs_nxt = in_tdata[8:2];
        hr_nxt = in_tdata[16:9];
        hd_nxt = in_tdata[24:17];
        err_nxt = 1'b0;
        st_nxt = ST_START; ph_nxt = '0; q_nxt = '0; bc_nxt = '0;
      end
    end else if (!scl_lvl(st_r, q_r) || scl) begin
      if (ph_r >= limit) begin
        ph_nxt = '0;
        q_nxt = q_r + 2'd1;
        if (q_r == 2'd1) begin
          if (is_send(st_r) && bc_r == 4'd8) sb_nxt = {7'd0, sda};
          else if (st_r == ST_RECV) sb_nxt = {sb_r[6:0], sda};
        end else if (q_r == 2'd3) begin
          q_nxt = '0;
          unique case (st_r)
            ST_START: begin
              st_nxt = ST_ADDR_W; sb_nxt = {hs_r, 1'b0}; bc_nxt = '0; ph_nxt = '0;
            end
            ST_RSTART: begin
              st_nxt = ST_ADDR_R; sb_nxt = {hs_r, 1'b1}; bc_nxt = '0;
            end
            ST_ADDR_W, ST_REG, ST_DATA, ST_ADDR_R: begin
              if (bc_r < 4'd8) bc_nxt = bc_r + 4'd1;
              else begin
                bc_nxt = '0;
                if (sb_r[0]) begin
                  err_nxt = 1'b1; lr_nxt = '0; st_nxt = ST_STOP;
                end else if (st_r == ST_ADDR_W) begin
                  st_nxt = ST_REG; sb_nxt = hr_r;
                end else if (st_r == ST_REG) begin
                  if (hm_r) st_nxt = ST_RSTART;
                  else begin
                    st_nxt = ST_DATA; sb_nxt = hd_r;
                  end
                end else if (st_r == ST_DATA) st_nxt = ST_STOP;
                else begin
                  st_nxt = ST_RECV; sb_nxt = '0; wc_nxt = tmo_r;
                end
              end
            end
            ST_RECV: begin
              if (bc_r < 4'd7) bc_nxt = bc_r + 4'd1;
              else begin
                lr_nxt = sb_nxt; st_nxt = ST_MNACK; bc_nxt = '0;
              end
            end
            ST_MNACK: begin
              st_nxt = ST_STOP; bc_nxt = '0;
            end
            ST_STOP: begin
              st_nxt = ST_IDLE; bc_nxt = '0; done = 1'b1;
            end
            default: st_nxt = ST_IDLE;
          endcase
          moved = st_nxt != prev_st;
        end
      end else begin
        ph_nxt = ph_r + PhaseOne;
      end
    end
    if (st_nxt == ST_RECV && !moved) begin
      wc_nxt = wc_nxt - 16'd1;
      if (wc_nxt == 16'd0) begin
        err_nxt = 1'b1; lr_nxt = '0; st_nxt = ST_STOP;
        ph_nxt = '0; q_nxt = '0; bc_nxt = '0;
      end
    end
    res = {3'd0, lr_nxt, err_nxt, done, st_nxt != ST_IDLE,
           sda_lvl(st_nxt, q_nxt, bc_nxt, sb_nxt), scl_lvl(st_nxt, q_nxt)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r <= DIVIDER_RESET; tmo_r <= TIMEOUT_RESET;
      st_r <= ST_IDLE; ph_r <= '0; q_r <= '0; bc_r <= '0; sb_r <= '0;
      hs_r <= '0; hr_r <= '0; hd_r <= '0; hm_r <= 1'b0; wc_r <= '0;
      err_r <= 1'b0; lr_r <= '0; ov_r <= 1'b0; sv_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_addr == CFG_CLOCK_DIVIDER) div_r <= cfg_wdata[7:0];
      if (cfg_we && cfg_addr == CFG_RECEIVE_TIMEOUT) tmo_r <= cfg_wdata;
      if (take) begin
        st_r <= st_nxt; ph_r <= ph_nxt; q_r <= q_nxt; bc_r <= bc_nxt;
        sb_r <= sb_nxt; hs_r <= hs_nxt; hr_r <= hr_nxt; hd_r <= hd_nxt;
        hm_r <= hm_nxt; wc_r <= wc_nxt; err_r <= err_nxt; lr_r <= lr_nxt;
      end
      if (!ov_r || out_tready) begin
        if (sv_r) begin
          ob_r <= sk_r; ov_r <= 1'b1; sv_r <= 1'b0;
        end else begin
          ob_r <= res; ov_r <= take;
        end
      end else if (take) begin
        sk_r <= res; sv_r <= 1'b1;
      end
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata = ob_r;

endmodule
`default_nettype wire
